[rtl/ssp_pkg.sv]
`default_nettype none

package ssp_pkg;

	// input item kinds
	localparam logic [1:0] MODE_BYTE    = 2'd0;
	localparam logic [1:0] MODE_TIMEOUT = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD     = 2'd1;
	localparam logic [1:0] ST_CHKSUM  = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_EXPECTED_ID   = 2'd0;
	localparam logic [1:0] REG_REQUEST_INSTR = 2'd1;
	localparam logic [1:0] REG_REQUEST_ADDR  = 2'd2;
	localparam logic [1:0] REG_READ_LENGTH   = 2'd3;

	// request instructions
	localparam logic [7:0] INST_PING  = 8'h01;
	localparam logic [7:0] INST_READ  = 8'h02;
	localparam logic [7:0] INST_WRITE = 8'h03;

	// first byte of an echoed request
	localparam logic [7:0] ECHO_PING  = 8'h02;
	localparam logic [7:0] ECHO_READ  = 8'h04;
	localparam logic [7:0] ECHO_WRITE = 8'h05;

	localparam logic [7:0] HDR_BYTE = 8'hFF;

	// echoed request prefix length
	localparam logic [5:0] ECHO_LEN = 6'd3;

	typedef struct packed {
		logic [7:0] expected_id;
		logic [7:0] request_instruction;
		logic [7:0] request_address;
		logic [7:0] read_length;
	} cfg_t;

	// one finished packet (or failure) handed from parser to emitter
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] id;
		logic [7:0] err;
		logic [5:0] fill;
		logic [7:0] p0;
		logic [7:0] p1;
		logic [7:0] p2;
	} job_t;

	typedef struct packed {
		logic [1:0] result_status;
		logic [7:0] data_byte;
		logic [5:0] byte_index;
		logic       has_data;
		logic       last;
		logic [7:0] reply_id;
		logic [7:0] servo_error;
		logic [5:0] param_total;
		logic       id_mismatch;
		logic       count_mismatch;
	} result_t;

endpackage

`default_nettype wire

[rtl/ssp_ram.sv]
`default_nettype none

module ssp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 58
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/ssp_queue.sv]
`default_nettype none

module ssp_queue import ssp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output job_t      pop_job,
	output logic      nonempty
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign pop_job  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("job pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("job popped from empty queue");

endmodule

`default_nettype wire

[rtl/ssp_front.sv]
`default_nettype none

module ssp_front import ssp_pkg::*; #(
	parameter int MAX_PACKET_LEN = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        mode,
	input  wire logic [7:0]                        rx_byte,
	input  wire logic                              busy,
	input  wire logic                              q_full,
	output logic                                   push,
	output job_t                                   job,
	output logic                                   ram_we,
	output logic [$clog2(MAX_PACKET_LEN-6)-1:0]    ram_waddr,
	output logic [7:0]                             ram_wdata
);

	localparam int         AW      = $clog2(MAX_PACKET_LEN - 6);
	localparam logic [7:0] LenMax  = 8'(MAX_PACKET_LEN - 4);
	localparam logic [6:0] HuntMax = 7'(MAX_PACKET_LEN);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_ID    = 3'd1;
	localparam logic [2:0] PH_LEN   = 3'd2;
	localparam logic [2:0] PH_ERR   = 3'd3;
	localparam logic [2:0] PH_PARAM = 3'd4;
	localparam logic [2:0] PH_CHK   = 3'd5;
	localparam logic [2:0] PH_DONE  = 3'd6;

	logic [2:0] phase_q, phase_d;
	logic       prev_hdr_q, prev_hdr_d;
	logic [6:0] bytes_seen_q, bytes_seen_d;
	logic [7:0] got_id_q, got_id_d;
	logic [7:0] got_len_q, got_len_d;
	logic [7:0] got_err_q, got_err_d;
	logic [7:0] sum_q, sum_d;
	logic [5:0] fill_q, fill_d;
	logic [7:0] p0_q, p1_q, p2_q;

	logic       accept;
	logic [7:0] sum_add;
	logic [6:0] bs_inc;
	logic [5:0] fill_inc;

	// hold parameter bytes back while the emitter still reads the store
	assign in_ready  = !q_full && !((phase_q == PH_PARAM) && busy);
	assign accept    = in_valid && in_ready;
	assign sum_add   = sum_q + rx_byte;
	assign bs_inc    = (bytes_seen_q < 7'd127) ? bytes_seen_q + 7'd1 : bytes_seen_q;
	assign fill_inc  = fill_q + 6'd1;
	assign ram_waddr = fill_q[AW-1:0];
	assign ram_wdata = rx_byte;

	always_comb begin
		phase_d      = phase_q;
		prev_hdr_d   = prev_hdr_q;
		bytes_seen_d = bytes_seen_q;
		got_id_d     = got_id_q;
		got_len_d    = got_len_q;
		got_err_d    = got_err_q;
		sum_d        = sum_q;
		fill_d       = fill_q;
		push         = 1'b0;
		ram_we       = 1'b0;
		job          = '0;
		job.id       = got_id_q;
		job.err      = got_err_q;
		job.fill     = fill_q;
		job.p0       = p0_q;
		job.p1       = p1_q;
		job.p2       = p2_q;
		if (accept) begin
			if (mode == MODE_RESTART) begin
				phase_d      = PH_HUNT;
				prev_hdr_d   = 1'b0;
				bytes_seen_d = 7'd0;
				got_id_d     = 8'd0;
				got_len_d    = 8'd0;
				got_err_d    = 8'd0;
				sum_d        = 8'd0;
				fill_d       = 6'd0;
			end else if (phase_q != PH_DONE && mode == MODE_TIMEOUT) begin
				push       = 1'b1;
				job        = '0;
				job.status = (phase_q == PH_HUNT && bytes_seen_q >= 7'd4) ? ST_BAD
				                                                          : ST_TIMEOUT;
				phase_d    = PH_DONE;
			end else if (phase_q != PH_DONE && mode == MODE_BYTE) begin
				unique case (phase_q)
					PH_HUNT: begin
						bytes_seen_d = bs_inc;
						if (prev_hdr_q && rx_byte == HDR_BYTE) begin
							prev_hdr_d = 1'b0;
							phase_d    = PH_ID;
						end else begin
							prev_hdr_d = (rx_byte == HDR_BYTE);
							if (bs_inc >= HuntMax) begin
								push       = 1'b1;
								job        = '0;
								job.status = ST_BAD;
								phase_d    = PH_DONE;
							end
						end
					end
					PH_ID: begin
						got_id_d = rx_byte;
						sum_d    = rx_byte;
						phase_d  = PH_LEN;
					end
					PH_LEN: begin
						if (rx_byte < 8'd2 || rx_byte > LenMax) begin
							push       = 1'b1;
							job        = '0;
							job.status = ST_BAD;
							phase_d    = PH_DONE;
						end else begin
							got_len_d = rx_byte;
							sum_d     = sum_add;
							phase_d   = PH_ERR;
						end
					end
					PH_ERR: begin
						got_err_d = rx_byte;
						sum_d     = sum_add;
						fill_d    = 6'd0;
						phase_d   = (got_len_q > 8'd2) ? PH_PARAM : PH_CHK;
					end
					PH_PARAM: begin
						ram_we = 1'b1;
						fill_d = fill_inc;
						sum_d  = sum_add;
						if ({2'b00, fill_inc} + 8'd2 >= got_len_q) begin
							phase_d = PH_CHK;
						end
					end
					PH_CHK: begin
						push       = 1'b1;
						job.status = (~sum_q != rx_byte) ? ST_CHKSUM : ST_OK;
						if (~sum_q != rx_byte) begin
							job = '0;
							job.status = ST_CHKSUM;
						end
						phase_d = PH_DONE;
					end
					default: begin
						phase_d = PH_DONE;
					end
				endcase
			end
		end
	end

	// keep the first three parameters for echo detection
	always_ff @(posedge clk) begin
		if (ram_we) begin
			if (fill_q == 6'd0) begin
				p0_q <= rx_byte;
			end
			if (fill_q == 6'd1) begin
				p1_q <= rx_byte;
			end
			if (fill_q == 6'd2) begin
				p2_q <= rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			prev_hdr_q   <= 1'b0;
			bytes_seen_q <= 7'd0;
			got_id_q     <= 8'd0;
			got_len_q    <= 8'd0;
			got_err_q    <= 8'd0;
			sum_q        <= 8'd0;
			fill_q       <= 6'd0;
		end else begin
			phase_q      <= phase_d;
			prev_hdr_q   <= prev_hdr_d;
			bytes_seen_q <= bytes_seen_d;
			got_id_q     <= got_id_d;
			got_len_q    <= got_len_d;
			got_err_q    <= got_err_d;
			sum_q        <= sum_d;
			fill_q       <= fill_d;
		end
	end

	a_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !busy) else $error("store written while emitter reads it");

	a_push_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> phase_q == PH_DONE) else $error("parser not finished after result");

endmodule

`default_nettype wire

[rtl/ssp_back.sv]
`default_nettype none

module ssp_back import ssp_pkg::*; #(
	parameter int MAX_PACKET_LEN = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire cfg_t                           cfg,
	input  wire logic                           job_valid,
	input  wire job_t                           job,
	output logic                                job_pop,
	output logic                                busy,
	output logic [$clog2(MAX_PACKET_LEN-6)-1:0] ram_raddr,
	input  wire logic [7:0]                     ram_rdata,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output result_t                             res
);

	localparam int AW = $clog2(MAX_PACKET_LEN - 6);

	localparam logic [1:0] B_IDLE   = 2'd0;
	localparam logic [1:0] B_DECIDE = 2'd1;
	localparam logic [1:0] B_READ   = 2'd2;
	localparam logic [1:0] B_LOAD   = 2'd3;

	logic [1:0] state_q, state_d;
	job_t       job_q;
	logic [5:0] count_q, idx_q;
	logic       off_q, cm_q, idm_q;
	logic       out_valid_q;
	result_t    res_q;

	logic       slot_free, load;
	result_t    load_val;
	logic       is_ping, is_read, is_write;
	logic       ping_echo, read_echo, write_echo;
	logic [5:0] eff_count;
	logic       eff_cm, eff_idm;
	logic [5:0] addr_full;
	logic       at_end;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign busy      = (state_q != B_IDLE);
	assign job_pop   = (state_q == B_IDLE) && job_valid;
	assign addr_full = idx_q + (off_q ? ECHO_LEN : 6'd0);
	assign ram_raddr = addr_full[AW-1:0];
	assign at_end    = (idx_q + 6'd1 == count_q);

	// strip an echoed request prefix
	always_comb begin
		is_ping    = (cfg.request_instruction == INST_PING);
		is_read    = (cfg.request_instruction == INST_READ);
		is_write   = (cfg.request_instruction == INST_WRITE);
		ping_echo  = is_ping && job_q.fill == ECHO_LEN && job_q.p0 == ECHO_PING &&
		             job_q.p1 == INST_PING;
		read_echo  = is_read &&
		             {3'b000, job_q.fill} == {1'b0, cfg.read_length} + 9'd3 &&
		             job_q.p0 == ECHO_READ && job_q.p1 == INST_READ &&
		             job_q.p2 == cfg.request_address;
		write_echo = is_write && job_q.fill == ECHO_LEN && job_q.p0 == ECHO_WRITE &&
		             job_q.p1 == INST_WRITE && job_q.p2 == cfg.request_address;
		if (ping_echo || write_echo) begin
			eff_count = 6'd0;
		end else if (read_echo) begin
			eff_count = cfg.read_length[5:0];
		end else begin
			eff_count = job_q.fill;
		end
		eff_cm  = is_read && ({2'b00, eff_count} != cfg.read_length);
		eff_idm = (job_q.id != cfg.expected_id);
	end

	always_comb begin
		state_d  = state_q;
		load     = 1'b0;
		load_val = '0;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					state_d = B_DECIDE;
				end
			end
			B_DECIDE: begin
				if (job_q.status != ST_OK) begin
					load_val.result_status = job_q.status;
					load_val.last          = 1'b1;
					if (slot_free) begin
						load    = 1'b1;
						state_d = B_IDLE;
					end
				end else if (eff_count == 6'd0) begin
					load_val.result_status  = ST_OK;
					load_val.last           = 1'b1;
					load_val.reply_id       = job_q.id;
					load_val.servo_error    = job_q.err;
					load_val.id_mismatch    = eff_idm;
					load_val.count_mismatch = eff_cm;
					if (slot_free) begin
						load    = 1'b1;
						state_d = B_IDLE;
					end
				end else begin
					state_d = B_READ;
				end
			end
			B_READ: begin
				state_d = B_LOAD;
			end
			B_LOAD: begin
				load_val.result_status  = ST_OK;
				load_val.data_byte      = ram_rdata;
				load_val.byte_index     = idx_q;
				load_val.has_data       = 1'b1;
				load_val.last           = at_end;
				load_val.reply_id       = job_q.id;
				load_val.servo_error    = job_q.err;
				load_val.param_total    = count_q;
				load_val.id_mismatch    = idm_q;
				load_val.count_mismatch = cm_q;
				if (slot_free) begin
					load    = 1'b1;
					state_d = at_end ? B_IDLE : B_READ;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (state_q == B_DECIDE) begin
			count_q <= eff_count;
			off_q   <= read_echo;
			cm_q    <= eff_cm;
			idm_q   <= eff_idm;
			idx_q   <= 6'd0;
		end else if (state_q == B_LOAD && load) begin
			idx_q <= idx_q + 6'd1;
		end
		if (load) begin
			res_q <= load_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res.has_data |-> res.byte_index < res.param_total)
		else $error("byte index beyond parameter count");

	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res.result_status != ST_OK |-> res.last && !res.has_data)
		else $error("failure result not a single-beat run");

endmodule

`default_nettype wire

[rtl/servo_status_packet_receiver.sv]
`default_nettype none

// Status-packet receiver for a half-duplex servo bus. Each input beat is a
// received byte, a timeout or a restart. The parser front end takes one beat
// per cycle while in_ready is high, hunts for the FF FF header, checks LEN and
// the checksum and writes the parameters into a store of MAX_PACKET_LEN-6
// bytes. A finished packet or failure goes through a two-entry queue to the
// emitter, which strips an echoed request prefix and sends the parameters as
// a run of results, each from one store read followed by one output load,
// or a single status result. Parameter bytes of the next packet are held off
// while the emitter still reads the store. After any result run the receiver
// ignores bytes and timeouts until a restart.
module servo_status_packet_receiver import ssp_pkg::*; #(
	parameter int MAX_PACKET_LEN = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      result_status,
	output logic [7:0]      data_byte,
	output logic [5:0]      byte_index,
	output logic            has_data,
	output logic            last,
	output logic [7:0]      reply_id,
	output logic [7:0]      servo_error,
	output logic [5:0]      param_total,
	output logic            id_mismatch,
	output logic            count_mismatch
);

	localparam int Depth = MAX_PACKET_LEN - 6;
	localparam int AW    = $clog2(Depth);

	cfg_t          cfg_q;
	job_t          push_job, pop_job;
	logic          push, pop, q_full, q_nonempty;
	logic          back_busy;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	result_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_id         <= 8'd1;
			cfg_q.request_instruction <= INST_PING;
			cfg_q.request_address     <= 8'd0;
			cfg_q.read_length         <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPECTED_ID:   cfg_q.expected_id         <= cfg_data;
				REG_REQUEST_INSTR: cfg_q.request_instruction <= cfg_data;
				REG_REQUEST_ADDR:  cfg_q.request_address     <= cfg_data;
				REG_READ_LENGTH:   cfg_q.read_length         <= cfg_data;
				default:           cfg_q                     <= cfg_q;
			endcase
		end
	end

	ssp_front #(
		.MAX_PACKET_LEN(MAX_PACKET_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.rx_byte  (rx_byte),
		.busy     (back_busy || q_nonempty),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata)
	);

	ssp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (pop),
		.pop_job (pop_job),
		.nonempty(q_nonempty)
	);

	ssp_ram #(
		.WIDTH(8),
		.DEPTH(Depth)
	) u_param_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ssp_back #(
		.MAX_PACKET_LEN(MAX_PACKET_LEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job_valid(q_nonempty),
		.job      (pop_job),
		.job_pop  (pop),
		.busy     (back_busy),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res      (res)
	);

	assign result_status  = res.result_status;
	assign data_byte      = res.data_byte;
	assign byte_index     = res.byte_index;
	assign has_data       = res.has_data;
	assign last           = res.last;
	assign reply_id       = res.reply_id;
	assign servo_error    = res.servo_error;
	assign param_total    = res.param_total;
	assign id_mismatch    = res.id_mismatch;
	assign count_mismatch = res.count_mismatch;

endmodule

`default_nettype wire

[tb/sv/tb_servo_status_packet_receiver.sv]
`timescale 1ns / 1ps

module tb_servo_status_packet_receiver;
	import ssp_pkg::*;

	localparam int PKT_MAX = 64;
	localparam int SETTLE = 12;
	localparam int BEATS_PER_PHASE = 55;
	localparam logic [1:0] MODE_NOP = 2'd3;

	typedef enum logic [2:0] {
		PH_HUNT, PH_ID, PH_LEN, PH_ERR, PH_PARAMS, PH_CHECK, PH_DONE
	} parse_ph_e;

	typedef struct packed {
		logic [1:0] md;
		logic [7:0] b;
		logic       typed;
		logic [1:0] st;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_EXPECTED_ID;
	logic [7:0] cfg_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] mode = MODE_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] result_status;
	logic [7:0] data_byte;
	logic [5:0] byte_index;
	logic       has_data;
	logic       last;
	logic [7:0] reply_id;
	logic [7:0] servo_error;
	logic [5:0] param_total;
	logic       id_mismatch;
	logic       count_mismatch;

	servo_status_packet_receiver #(.MAX_PACKET_LEN(PKT_MAX)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_status(result_status), .data_byte(data_byte), .byte_index(byte_index),
		.has_data(has_data), .last(last), .reply_id(reply_id),
		.servo_error(servo_error), .param_total(param_total),
		.id_mismatch(id_mismatch), .count_mismatch(count_mismatch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver copy: parse state and request registers
	parse_ph_e  parse_ph;
	logic       prev_ff;
	int         hunt_count;
	logic [7:0] pkt_id, pkt_len, pkt_err, pkt_sum;
	logic [7:0] pkt_params [0:PKT_MAX-1];
	int         pkt_fill;
	logic [7:0] cfg_id = 8'd1;
	logic [7:0] cfg_inst = INST_PING;
	logic [7:0] cfg_addr = 8'd0;
	logic [7:0] cfg_rlen = 8'd0;

	result_t beat_out[$];
	result_t replies_due[$];
	int      mismatches = 0;
	int      beats_sent = 0;
	int      idle_pct = 0;
	int      stall_left = 0;

	stim_row_t directed_rows [28] = '{
		'{MODE_TIMEOUT, 8'h00, 1'b1, ST_TIMEOUT},
		'{MODE_RESTART, 8'h00, 1'b0, ST_OK},
		// ping reply carrying an echoed request, nothing left after stripping
		'{MODE_BYTE, 8'hFF, 1'b0, ST_OK},
		'{MODE_BYTE, 8'hFF, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h01, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h05, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h00, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h02, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h01, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h7E, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h78, 1'b0, ST_OK},
		'{MODE_RESTART, 8'hFF, 1'b0, ST_OK},
		'{MODE_BYTE, 8'hFF, 1'b0, ST_OK},
		'{MODE_BYTE, 8'hFF, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h00, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h01, 1'b1, ST_BAD},
		'{MODE_RESTART, 8'h00, 1'b0, ST_OK},
		'{MODE_BYTE, 8'hFF, 1'b0, ST_OK},
		'{MODE_BYTE, 8'hFF, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h00, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h3D, 1'b1, ST_BAD},
		'{MODE_RESTART, 8'h00, 1'b0, ST_OK},
		'{MODE_BYTE, 8'hFF, 1'b0, ST_OK},
		'{MODE_BYTE, 8'hFF, 1'b0, ST_OK},
		'{MODE_BYTE, 8'hFE, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h02, 1'b0, ST_OK},
		'{MODE_BYTE, 8'hFF, 1'b0, ST_OK},
		'{MODE_BYTE, 8'h55, 1'b1, ST_CHKSUM}
	};

	function automatic result_t status_result(input logic [1:0] st);
		result_t r;
		r = '0;
		r.result_status = st;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic logic [7:0] param_at(input int i);
		return (i < pkt_fill) ? pkt_params[i] : 8'h00;
	endfunction

	function automatic void clear_parse();
		parse_ph = PH_HUNT;
		prev_ff = 1'b0;
		hunt_count = 0;
		pkt_id = 8'h00;
		pkt_len = 8'h00;
		pkt_err = 8'h00;
		pkt_sum = 8'h00;
		pkt_fill = 0;
	endfunction

	function automatic void close_with(input logic [1:0] st);
		beat_out.push_back(status_result(st));
		parse_ph = PH_DONE;
	endfunction

	// strip an echoed request, then lay the parameters out as a run
	function automatic void emit_packet();
		int cnt, off, read_cnt, i;
		logic idm, cm;
		result_t r;
		cnt = pkt_fill;
		off = 0;
		read_cnt = (cfg_inst == INST_READ) ? int'(cfg_rlen) : 0;
		idm = (pkt_id != cfg_id);
		if (cfg_inst == INST_PING && cnt == 3 && param_at(0) == ECHO_PING &&
		    param_at(1) == INST_PING) begin
			off = 3;
			cnt = 0;
		end else if (cfg_inst == INST_READ && cnt == read_cnt + 3 &&
		             param_at(0) == ECHO_READ && param_at(1) == INST_READ &&
		             param_at(2) == cfg_addr) begin
			off = 3;
			cnt = read_cnt;
		end else if (cfg_inst == INST_WRITE && cnt == 3 && param_at(0) == ECHO_WRITE &&
		             param_at(1) == INST_WRITE && param_at(2) == cfg_addr) begin
			off = 3;
			cnt = 0;
		end
		cm = (cfg_inst == INST_READ && cnt != read_cnt);
		r = '0;
		r.result_status = ST_OK;
		r.reply_id = pkt_id;
		r.servo_error = pkt_err;
		r.id_mismatch = idm;
		r.count_mismatch = cm;
		if (cnt == 0) begin
			r.last = 1'b1;
			beat_out.push_back(r);
		end else begin
			r.has_data = 1'b1;
			r.param_total = cnt[5:0];
			for (i = 0; i < cnt; i++) begin
				r.data_byte = param_at(off + i);
				r.byte_index = i[5:0];
				r.last = (i + 1 == cnt);
				beat_out.push_back(r);
			end
		end
		parse_ph = PH_DONE;
	endfunction

	function automatic void parse_beat(input logic [1:0] m, input logic [7:0] b);
		beat_out.delete();
		if (m == MODE_RESTART) begin
			clear_parse();
			return;
		end
		if ((m != MODE_BYTE && m != MODE_TIMEOUT) || parse_ph == PH_DONE)
			return;
		if (m == MODE_TIMEOUT) begin
			if (parse_ph == PH_HUNT && hunt_count >= 4)
				close_with(ST_BAD);
			else
				close_with(ST_TIMEOUT);
			return;
		end
		case (parse_ph)
			PH_HUNT: begin
				if (hunt_count < 127)
					hunt_count++;
				if (prev_ff && b == HDR_BYTE) begin
					prev_ff = 1'b0;
					parse_ph = PH_ID;
				end else begin
					prev_ff = (b == HDR_BYTE);
					if (hunt_count >= PKT_MAX)
						close_with(ST_BAD);
				end
			end
			PH_ID: begin
				pkt_id = b;
				pkt_sum = b;
				parse_ph = PH_LEN;
			end
			PH_LEN: begin
				if (b < 2 || int'(b) > PKT_MAX - 4) begin
					close_with(ST_BAD);
				end else begin
					pkt_len = b;
					pkt_sum = pkt_sum + b;
					parse_ph = PH_ERR;
				end
			end
			PH_ERR: begin
				pkt_err = b;
				pkt_sum = pkt_sum + b;
				pkt_fill = 0;
				parse_ph = (pkt_len > 2) ? PH_PARAMS : PH_CHECK;
			end
			PH_PARAMS: begin
				if (pkt_fill < PKT_MAX) begin
					pkt_params[pkt_fill] = b;
					pkt_fill++;
				end
				pkt_sum = pkt_sum + b;
				if (pkt_fill + 2 >= int'(pkt_len))
					parse_ph = PH_CHECK;
			end
			PH_CHECK: begin
				if ((~pkt_sum) != b)
					close_with(ST_CHKSUM);
				else
					emit_packet();
			end
			default: parse_ph = PH_DONE;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic compare_result(input result_t got, input result_t want);
		if (got.result_status !== want.result_status)
			report_mismatch("result_status", got.result_status, want.result_status);
		if (got.data_byte !== want.data_byte)
			report_mismatch("data_byte", got.data_byte, want.data_byte);
		if (got.byte_index !== want.byte_index)
			report_mismatch("byte_index", got.byte_index, want.byte_index);
		if (got.has_data !== want.has_data)
			report_mismatch("has_data", got.has_data, want.has_data);
		if (got.last !== want.last)
			report_mismatch("last", got.last, want.last);
		if (got.reply_id !== want.reply_id)
			report_mismatch("reply_id", got.reply_id, want.reply_id);
		if (got.servo_error !== want.servo_error)
			report_mismatch("servo_error", got.servo_error, want.servo_error);
		if (got.param_total !== want.param_total)
			report_mismatch("param_total", got.param_total, want.param_total);
		if (got.id_mismatch !== want.id_mismatch)
			report_mismatch("id_mismatch", got.id_mismatch, want.id_mismatch);
		if (got.count_mismatch !== want.count_mismatch)
			report_mismatch("count_mismatch", got.count_mismatch, want.count_mismatch);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && out_ready) begin
			got = {result_status, data_byte, byte_index, has_data, last, reply_id,
			       servo_error, param_total, id_mismatch, count_mismatch};
			if (replies_due.size() == 0)
				report_mismatch("result with nothing due, status", got.result_status, 0);
			else
				compare_result(got, replies_due.pop_front());
		end
	end

	// typed rows carry their own status-only expectation instead of the prediction
	task automatic send_beat(input logic [1:0] m, input logic [7:0] b, input logic typed,
	                         input logic [1:0] st);
		int gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		parse_beat(m, b);
		if (typed)
			replies_due.push_back(status_result(st));
		else
			foreach (beat_out[i]) replies_due.push_back(beat_out[i]);
		if (m != MODE_NOP)
			beats_sent++;
	endtask

	task automatic beat(input logic [1:0] m, input logic [7:0] b);
		send_beat(m, b, 1'b0, ST_OK);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] id, input logic [7:0] inst,
	                          input logic [7:0] addr, input logic [7:0] rlen);
		logic [1:0] regs [4];
		logic [7:0] vals [4];
		regs = '{REG_EXPECTED_ID, REG_REQUEST_INSTR, REG_REQUEST_ADDR, REG_READ_LENGTH};
		vals = '{id, inst, addr, rlen};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg_id = id;
		cfg_inst = inst;
		cfg_addr = addr;
		cfg_rlen = rlen;
	endtask

	task automatic good_packet();
		logic [7:0] pl[$];
		logic [7:0] frame[$];
		logic [7:0] id, len, err, sum, chk;
		int k, n, cut;
		k = $urandom_range(0, 9);
		if (cfg_inst == INST_PING && k < 4) begin
			pl = '{ECHO_PING, INST_PING, 8'($urandom)};
		end else if (cfg_inst == INST_READ && k < 5 && cfg_rlen <= 55) begin
			pl = '{ECHO_READ, INST_READ, (k == 0) ? 8'($urandom) : cfg_addr};
			repeat (cfg_rlen) pl.push_back(8'($urandom));
		end else if (cfg_inst == INST_READ && k < 7 && cfg_rlen <= 58) begin
			repeat (cfg_rlen) pl.push_back(8'($urandom));
		end else if (cfg_inst == INST_WRITE && k < 4) begin
			pl = '{ECHO_WRITE, INST_WRITE, (k == 0) ? 8'($urandom) : cfg_addr};
		end else begin
			if (k == 9)
				n = $urandom_range(0, 1) ? 58 : $urandom_range(7, 57);
			else
				n = $urandom_range(0, 6);
			repeat (n) pl.push_back(8'($urandom));
		end
		id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : cfg_id;
		len = 8'(pl.size() + 2);
		err = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
		sum = id + len + err;
		foreach (pl[i]) sum = sum + pl[i];
		chk = ~sum;
		if ($urandom_range(0, 9) == 0)
			chk = chk ^ 8'($urandom_range(1, 255));
		// leading line noise never contains the header byte
		repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom_range(0, 254)));
		frame.push_back(HDR_BYTE);
		frame.push_back(HDR_BYTE);
		frame.push_back(id);
		frame.push_back(len);
		frame.push_back(err);
		foreach (pl[i]) frame.push_back(pl[i]);
		frame.push_back(chk);
		cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, frame.size() - 1) : frame.size();
		for (int i = 0; i < cut; i++)
			beat(MODE_BYTE, frame[i]);
		if (cut < frame.size())
			beat(MODE_TIMEOUT, 8'($urandom));
	endtask

	task automatic transaction();
		int r;
		logic ff;
		logic [7:0] b;
		beat(MODE_RESTART, 8'($urandom));
		r = $urandom_range(0, 99);
		if (r < 72) begin
			good_packet();
		end else if (r < 82) begin
			beat(MODE_BYTE, HDR_BYTE);
			beat(MODE_BYTE, HDR_BYTE);
			beat(MODE_BYTE, 8'($urandom));
			case ($urandom_range(0, 3))
				0: beat(MODE_BYTE, 8'd0);
				1: beat(MODE_BYTE, 8'd1);
				2: beat(MODE_BYTE, 8'(PKT_MAX - 3));
				default: beat(MODE_BYTE, 8'($urandom_range(PKT_MAX - 2, 255)));
			endcase
		end else if (r < 85) begin
			// long hunt with single header bytes only
			ff = 1'b0;
			repeat ($urandom_range(PKT_MAX, PKT_MAX + 4)) begin
				b = (!ff && $urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom_range(0, 254));
				ff = (b == HDR_BYTE);
				beat(MODE_BYTE, b);
			end
		end else begin
			repeat ($urandom_range(1, 8)) beat(2'($urandom_range(0, 3)), 8'($urandom));
		end
		// traffic after the run is over is dropped until the next restart
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 2))
				0: beat(MODE_BYTE, 8'($urandom));
				1: beat(MODE_TIMEOUT, 8'($urandom));
				default: beat(MODE_NOP, 8'($urandom));
			endcase
		end
	endtask

	initial begin
		int phase_end;
		clear_parse();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 20;
		foreach (directed_rows[i])
			send_beat(directed_rows[i].md, directed_rows[i].b, directed_rows[i].typed,
			          directed_rows[i].st);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					set_config(8'd1, INST_PING, 8'd0, 8'd0);
					idle_pct = 30;
				end
				1: begin
					set_config(8'd0, INST_READ, 8'd0, 8'd0);
					idle_pct = 0;
				end
				2: begin
					set_config(8'd255, INST_READ, 8'd255, 8'd55);
					idle_pct = 40;
				end
				3: begin
					set_config(8'($urandom), INST_WRITE, 8'($urandom), 8'd255);
					idle_pct = 25;
				end
				4: begin
					set_config(8'($urandom), 8'($urandom_range(0, 1) ? 0 : 255),
					           8'($urandom), 8'($urandom_range(0, 7)));
					idle_pct = 20;
				end
				default: begin
					set_config(8'($urandom), INST_READ, 8'($urandom),
					           8'($urandom_range(1, 6)));
					idle_pct = 0;
				end
			endcase
			phase_end = beats_sent + BEATS_PER_PHASE;
			while (beats_sent < phase_end)
				transaction();
		end

		wait_idle();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
